// ===== sv/pcg32_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PCG32 random generator: command codes, field widths and constants.
// It has no dependencies. The interfaces and the top level use it.
package pcg32_pkg;

   localparam int unsigned CmdWidth   = 3;
   localparam int unsigned BoundWidth = 32;
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned NumWidth   = 32;
   localparam int unsigned SeqWidth   = 63;

   typedef logic [CmdWidth-1:0] cmd_type;

   localparam cmd_type CMD_DRAW    = 3'd0;
   localparam cmd_type CMD_BOUNDED = 3'd1;
   localparam cmd_type CMD_FLOAT   = 3'd2;
   localparam cmd_type CMD_ADVANCE = 3'd3;
   localparam cmd_type CMD_RESEED  = 3'd4;
   localparam cmd_type CMD_DIST    = 3'd5;

   localparam logic [63:0] LCG_MULT   = 64'h5851f42d4c957f2d;
   localparam logic [63:0] INIT_STATE = 64'h853c49e6748fea9b;
   localparam logic [63:0] INIT_INC   = 64'hda3e39cb94b95bdb;
   // Largest float below one, returned when rounding reaches 1.0.
   localparam logic [31:0] FLOAT_CLAMP = 32'h3f7fffff;

endpackage

// ===== sv/pcg32_req_if.sv =====
`timescale 1ns / 1ps
// Command channel of the PCG32 generator: valid/ready handshake and one command beat.
// Depends on pcg32_pkg for the field widths.
interface pcg32_req_if;
   logic                                   valid;
   logic                                   ready;
   pcg32_pkg::cmd_type                     command;
   logic [pcg32_pkg::BoundWidth-1:0]       bound;
   logic signed [pcg32_pkg::WordWidth-1:0] delta;
   logic [pcg32_pkg::WordWidth-1:0]        other_state;

   modport source (output valid, command, bound, delta, other_state, input ready);
   modport sink   (input valid, command, bound, delta, other_state, output ready);
endinterface

// ===== sv/pcg32_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the PCG32 generator: valid/ready handshake and one result beat.
// Depends on pcg32_pkg for the field widths.
interface pcg32_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [pcg32_pkg::NumWidth-1:0]         number;
   logic [pcg32_pkg::NumWidth-1:0]         float_bits;
   logic signed [pcg32_pkg::WordWidth-1:0] distance;
   logic                                   error;

   modport source (output valid, number, float_bits, distance, error, input ready);
   modport sink   (input valid, number, float_bits, distance, error, output ready);
endinterface

// ===== sv/pcg32_random_generator.sv =====
`timescale 1ns / 1ps
// One command at a time; a shared 32x32 multiplier builds each 64-bit product from three
// partial products, and a one-bit-per-cycle remainder divider serves bounded draws.
// Synchronous active-high reset restores the default state, increment and stream.
// Depends on pcg32_pkg, pcg32_req_if and pcg32_rsp_if.
module pcg32_random_generator (
   input  logic                           clock,
   input  logic                           reset,
   pcg32_req_if.sink                      req_if,
   pcg32_rsp_if.source                    rsp_if,
   input  logic                           csr_we,
   input  logic [pcg32_pkg::SeqWidth-1:0] csr_wdata
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_MUL      = 5'd1;
   localparam logic [4:0] S_DIV      = 5'd2;
   localparam logic [4:0] S_DRAW     = 5'd3;
   localparam logic [4:0] S_DRAW_FIN = 5'd4;
   localparam logic [4:0] S_BND_THR  = 5'd5;
   localparam logic [4:0] S_BND_FIN  = 5'd6;
   localparam logic [4:0] S_NORM     = 5'd7;
   localparam logic [4:0] S_FRND     = 5'd8;
   localparam logic [4:0] S_ADV_LOOP = 5'd9;
   localparam logic [4:0] S_ADV_A1   = 5'd10;
   localparam logic [4:0] S_ADV_A2   = 5'd11;
   localparam logic [4:0] S_ADV_C2   = 5'd12;
   localparam logic [4:0] S_ADV_C3   = 5'd13;
   localparam logic [4:0] S_ADV_END  = 5'd14;
   localparam logic [4:0] S_DST_LOOP = 5'd15;
   localparam logic [4:0] S_DST_A    = 5'd16;
   localparam logic [4:0] S_RSD_FIN  = 5'd17;
   localparam logic [4:0] S_OUT      = 5'd18;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [63:0] gen_ff, gen_in, inc_ff, inc_in;
   logic [62:0] seq_ff, seq_in;
   pcg32_pkg::cmd_type cmd_ff, cmd_in;
   logic [31:0] bound_ff, bound_in, thr_ff, thr_in, perm_ff, perm_in;
   logic [63:0] am_ff, am_in, ap_ff, ap_in, cm_ff, cm_in, cp_ff, cp_in, d_ff, d_in;
   logic [6:0]  idx_ff, idx_in;
   // Multiply unit registers.
   logic [63:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, prod_ff, acc_ff, acc_in;
   logic [1:0]  mcnt_ff, mcnt_in;
   logic [31:0] mop_a, mop_b;
   // Divider registers.
   logic [31:0] dn_ff, dn_in, rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [32:0] dtrial;
   // Float conversion registers.
   logic [31:0] fu_ff, fu_in;
   logic [5:0]  fp_ff, fp_in;
   // Result registers.
   logic [31:0] num_ff, num_in, fbits_ff, fbits_in;
   logic [63:0] dist_ff, dist_in;
   logic        err_ff, err_in;
   // Combinational helpers.
   logic [31:0] xs;
   logic [63:0] rot2;
   logic [7:0]  frem;
   logic        fup;
   logic [24:0] fm25;
   logic [23:0] fm;
   logic [5:0]  fpe;
   logic [7:0]  fexp;
   logic [5:0]  bitsel;

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = (state_ff == S_OUT);
   assign rsp_if.number     = num_ff;
   assign rsp_if.float_bits = fbits_ff;
   assign rsp_if.distance   = dist_ff;
   assign rsp_if.error      = err_ff;

   // Output permutation of the current state (xorshift high, random rotate).
   assign xs   = 32'(((gen_ff >> 18) ^ gen_ff) >> 27);
   assign rot2 = {xs, xs} >> gen_ff[63:59];

   // Operand halves for the shared multiplier, by partial product.
   always_comb begin
      mop_a = (mcnt_ff == 2'd2) ? mul_a_ff[63:32] : mul_a_ff[31:0];
      mop_b = (mcnt_ff == 2'd1) ? mul_b_ff[63:32] : mul_b_ff[31:0];
   end

   // Divider trial value: the remainder shifted left with the next dividend bit.
   assign dtrial = {rem_ff, dn_ff[31]};

   // Rounding of the normalized draw to 24 significant bits.
   always_comb begin
      frem = fu_ff[7:0];
      fup  = (frem > 8'h80) || ((frem == 8'h80) && fu_ff[8]);
      fm25 = {1'b0, fu_ff[31:8]} + {24'd0, fup};
      fm   = fm25[24] ? fm25[24:1] : fm25[23:0];
      fpe  = fm25[24] ? fp_ff + 6'd1 : fp_ff;
      fexp = 8'({2'b00, fpe} + 8'd95);
   end

   assign bitsel = idx_ff[5:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      gen_in   = gen_ff;
      inc_in   = inc_ff;
      seq_in   = csr_we ? csr_wdata : seq_ff;
      cmd_in   = cmd_ff;
      bound_in = bound_ff;
      thr_in   = thr_ff;
      perm_in  = perm_ff;
      am_in    = am_ff;
      ap_in    = ap_ff;
      cm_in    = cm_ff;
      cp_in    = cp_ff;
      d_in     = d_ff;
      idx_in   = idx_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      mcnt_in  = mcnt_ff;
      dn_in    = dn_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      fu_in    = fu_ff;
      fp_in    = fp_ff;
      num_in   = num_ff;
      fbits_in = fbits_ff;
      dist_in  = dist_ff;
      err_in   = err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.command;
               bound_in = req_if.bound;
               num_in   = '0;
               fbits_in = '0;
               dist_in  = '0;
               err_in   = 1'b0;
               cm_in    = pcg32_pkg::LCG_MULT;
               cp_in    = inc_ff;
               ap_in    = '0;
               idx_in   = '0;
               if (req_if.command == pcg32_pkg::CMD_DIST) begin
                  am_in = req_if.other_state;
                  d_in  = '0;
               end else begin
                  am_in = 64'd1;
                  d_in  = req_if.delta;
               end
               if (req_if.command == pcg32_pkg::CMD_DRAW
                   || req_if.command == pcg32_pkg::CMD_FLOAT) begin
                  state_in = S_DRAW;
               end else if (req_if.command == pcg32_pkg::CMD_BOUNDED) begin
                  if (req_if.bound == '0) begin
                     err_in   = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     dn_in    = ~req_if.bound + 32'd1;
                     rem_in   = '0;
                     dcnt_in  = '0;
                     ret_in   = S_BND_THR;
                     state_in = S_DIV;
                  end
               end else if (req_if.command == pcg32_pkg::CMD_ADVANCE) begin
                  state_in = S_ADV_LOOP;
               end else if (req_if.command == pcg32_pkg::CMD_RESEED) begin
                  inc_in   = {seq_ff, 1'b1};
                  mul_a_in = {seq_ff, 1'b1} + pcg32_pkg::INIT_STATE;
                  mul_b_in = pcg32_pkg::LCG_MULT;
                  mcnt_in  = '0;
                  ret_in   = S_RSD_FIN;
                  state_in = S_MUL;
               end else if (req_if.command == pcg32_pkg::CMD_DIST) begin
                  state_in = S_DST_LOOP;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         // 64-bit product modulo 2^64 from three partial products.
         S_MUL: begin
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd1) begin
               acc_in = prod_ff;
            end else if (mcnt_ff != 2'd0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            end
            if (mcnt_ff == 2'd3) begin
               state_in = ret_ff;
            end
         end
         // Restoring remainder, one dividend bit per cycle.
         S_DIV: begin
            if (dtrial >= {1'b0, bound_ff}) begin
               rem_in = 32'(dtrial - {1'b0, bound_ff});
            end else begin
               rem_in = dtrial[31:0];
            end
            dn_in   = {dn_ff[30:0], 1'b0};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               state_in = ret_ff;
            end
         end
         S_DRAW: begin
            perm_in  = rot2[31:0];
            mul_a_in = gen_ff;
            mul_b_in = pcg32_pkg::LCG_MULT;
            mcnt_in  = '0;
            ret_in   = S_DRAW_FIN;
            state_in = S_MUL;
         end
         S_DRAW_FIN: begin
            gen_in = acc_ff + inc_ff;
            if (cmd_ff == pcg32_pkg::CMD_FLOAT) begin
               fu_in    = perm_ff;
               fp_in    = 6'd31;
               state_in = S_NORM;
            end else if (cmd_ff == pcg32_pkg::CMD_BOUNDED) begin
               if (perm_ff < thr_ff) begin
                  state_in = S_DRAW;
               end else begin
                  dn_in    = perm_ff;
                  rem_in   = '0;
                  dcnt_in  = '0;
                  ret_in   = S_BND_FIN;
                  state_in = S_DIV;
               end
            end else begin
               num_in   = perm_ff;
               state_in = S_OUT;
            end
         end
         S_BND_THR: begin
            thr_in   = rem_ff;
            state_in = S_DRAW;
         end
         S_BND_FIN: begin
            num_in   = rem_ff;
            state_in = S_OUT;
         end
         // Shift left until the leading one reaches the top bit; a zero draw gives 0.0.
         S_NORM: begin
            if (fu_ff == '0) begin
               state_in = S_OUT;
            end else if (fu_ff[31]) begin
               state_in = S_FRND;
            end else begin
               fu_in = {fu_ff[30:0], 1'b0};
               fp_in = fp_ff - 6'd1;
            end
         end
         S_FRND: begin
            if (fpe[5]) begin
               fbits_in = pcg32_pkg::FLOAT_CLAMP;
            end else begin
               fbits_in = {1'b0, fexp, fm[22:0]};
            end
            state_in = S_OUT;
         end
         // Jump ahead by squaring the step transform for each delta bit.
         S_ADV_LOOP: begin
            mcnt_in  = '0;
            state_in = S_MUL;
            if (d_ff == '0) begin
               mul_a_in = am_ff;
               mul_b_in = gen_ff;
               ret_in   = S_ADV_END;
            end else if (d_ff[0]) begin
               mul_a_in = am_ff;
               mul_b_in = cm_ff;
               ret_in   = S_ADV_A1;
            end else begin
               mul_a_in = cm_ff + 64'd1;
               mul_b_in = cp_ff;
               ret_in   = S_ADV_C2;
            end
         end
         S_ADV_A1: begin
            am_in    = acc_ff;
            mul_a_in = ap_ff;
            mul_b_in = cm_ff;
            mcnt_in  = '0;
            ret_in   = S_ADV_A2;
            state_in = S_MUL;
         end
         S_ADV_A2: begin
            ap_in    = acc_ff + cp_ff;
            mul_a_in = cm_ff + 64'd1;
            mul_b_in = cp_ff;
            mcnt_in  = '0;
            ret_in   = S_ADV_C2;
            state_in = S_MUL;
         end
         S_ADV_C2: begin
            cp_in    = acc_ff;
            mul_a_in = cm_ff;
            mul_b_in = cm_ff;
            mcnt_in  = '0;
            ret_in   = S_ADV_C3;
            state_in = S_MUL;
         end
         S_ADV_C3: begin
            cm_in = acc_ff;
            if (cmd_ff == pcg32_pkg::CMD_DIST) begin
               idx_in   = idx_ff + 7'd1;
               state_in = S_DST_LOOP;
            end else begin
               d_in     = d_ff >> 1;
               state_in = S_ADV_LOOP;
            end
         end
         S_ADV_END: begin
            gen_in   = acc_ff + ap_ff;
            state_in = S_OUT;
         end
         // Bitwise distance search; am holds the walking state, d the distance.
         S_DST_LOOP: begin
            mcnt_in = '0;
            if (idx_ff[6] || am_ff == gen_ff) begin
               dist_in  = d_ff;
               state_in = S_OUT;
            end else if (gen_ff[bitsel] != am_ff[bitsel]) begin
               d_in     = d_ff | (64'd1 << bitsel);
               mul_a_in = am_ff;
               mul_b_in = cm_ff;
               ret_in   = S_DST_A;
               state_in = S_MUL;
            end else begin
               mul_a_in = cm_ff + 64'd1;
               mul_b_in = cp_ff;
               ret_in   = S_ADV_C2;
               state_in = S_MUL;
            end
         end
         S_DST_A: begin
            am_in    = acc_ff + cp_ff;
            mul_a_in = cm_ff + 64'd1;
            mul_b_in = cp_ff;
            mcnt_in  = '0;
            ret_in   = S_ADV_C2;
            state_in = S_MUL;
         end
         S_RSD_FIN: begin
            gen_in   = acc_ff + inc_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gen_ff   <= pcg32_pkg::INIT_STATE;
         inc_ff   <= pcg32_pkg::INIT_INC;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
         inc_ff   <= inc_in;
         seq_ff   <= seq_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      cmd_ff   <= cmd_in;
      bound_ff <= bound_in;
      thr_ff   <= thr_in;
      perm_ff  <= perm_in;
      am_ff    <= am_in;
      ap_ff    <= ap_in;
      cm_ff    <= cm_in;
      cp_ff    <= cp_in;
      d_ff     <= d_in;
      idx_ff   <= idx_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff  <= {32'd0, mop_a} * {32'd0, mop_b};
      acc_ff   <= acc_in;
      mcnt_ff  <= mcnt_in;
      dn_ff    <= dn_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      fu_ff    <= fu_in;
      fp_ff    <= fp_in;
      num_ff   <= num_in;
      fbits_ff <= fbits_in;
      dist_ff  <= dist_in;
      err_ff   <= err_in;
   end

endmodule

// ===== sv/pcg32_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the PCG32 generator, bound to the top level.
// Depends on the top level's ports only.
module pcg32_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_number,
   input logic [31:0] rsp_float_bits,
   input logic [63:0] rsp_distance,
   input logic        rsp_error
);

   // No result beat right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number)
      && $stable(rsp_float_bits) && $stable(rsp_distance) && $stable(rsp_error))
      else $error("stalled result changed");

   // An accepted command keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // Only one command is in flight: no new command while a result waits.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   // A zero-bound error carries no other result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_number == '0 && rsp_float_bits == '0
      && rsp_distance == '0)
      else $error("error beat with data");

endmodule

bind pcg32_random_generator pcg32_checker u_pcg32_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_number     (rsp_if.number),
   .rsp_float_bits (rsp_if.float_bits),
   .rsp_distance   (rsp_if.distance),
   .rsp_error      (rsp_if.error)
);
